// ----- rtl/tco_pkg.sv -----
// ----------------------------------------------------------------------------
// tco_pkg: shared types and constants for the 8-bit compare/overflow timer
// Mode codes, register addresses, control bit positions and the result bundle.
// ----------------------------------------------------------------------------
package tco_pkg;

  localparam int unsigned MODE_W = 2;
  localparam int unsigned ADDR_W = 8;
  localparam int unsigned DATA_W = 8;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

  // Register map
  localparam logic [ADDR_W-1:0] ADDR_CONTROL = 8'h00;
  localparam logic [ADDR_W-1:0] ADDR_COUNT   = 8'h04;
  localparam logic [ADDR_W-1:0] ADDR_COMPARE = 8'h08;

  // Control register bits
  localparam int unsigned CTRL_COUNT_EN = 0;
  localparam int unsigned CTRL_CMP_IE   = 1;
  localparam int unsigned CTRL_OVF_IE   = 2;

  // One result transaction
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              compare_irq;
    logic              overflow_irq;
  } tco_result_t;

endpackage

// ----- rtl/tco_core.sv -----
// ----------------------------------------------------------------------------
// tco_core: timer register file and per-item logic
// Holds count, control and compare; computes one result per item and
// updates the registers when the item advances.
// ----------------------------------------------------------------------------
module tco_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [tco_pkg::MODE_W-1:0]  mode,
  input  logic [tco_pkg::ADDR_W-1:0]  address,
  input  logic [tco_pkg::DATA_W-1:0]  write_data,
  output tco_pkg::tco_result_t        result
);
  import tco_pkg::*;

  logic [DATA_W-1:0] count_r,   count_nxt;
  logic [DATA_W-1:0] control_r, control_nxt;
  logic [DATA_W-1:0] compare_r, compare_nxt;
  logic [DATA_W-1:0] count_inc;

  assign count_inc = count_r + {{(DATA_W-1){1'b0}}, 1'b1};

  // Decode the item: next register values and the result
  always_comb begin
    count_nxt   = count_r;
    control_nxt = control_r;
    compare_nxt = compare_r;
    result      = '0;
    unique case (mode)
      MODE_TICK: begin
        if (control_r[CTRL_COUNT_EN]) begin
          count_nxt           = count_inc;
          result.compare_irq  = control_r[CTRL_CMP_IE] && (count_inc == compare_r);
          result.overflow_irq = control_r[CTRL_OVF_IE] && (count_inc == '0);
        end
      end
      MODE_READ: begin
        unique case (address)
          ADDR_CONTROL: result.read_data = control_r;
          ADDR_COUNT:   result.read_data = count_r;
          ADDR_COMPARE: result.read_data = compare_r;
          default:      result.read_data = '0;
        endcase
      end
      MODE_WRITE: begin
        unique case (address)
          ADDR_CONTROL: control_nxt = write_data;
          ADDR_COMPARE: compare_nxt = write_data;
          default:      ;
        endcase
      end
      default: begin
        count_nxt   = '0;
        control_nxt = '0;
        compare_nxt = '0;
      end
    endcase
  end

  // Commit register updates when the item advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      control_r <= '0;
      compare_r <= '0;
    end else if (fire) begin
      count_r   <= count_nxt;
      control_r <= control_nxt;
      compare_r <= compare_nxt;
    end
  end

  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    fire && mode == MODE_CLEAR |=> count_r == '0 && control_r == '0 && compare_r == '0)
    else $error("clear did not zero the registers");

  a_frozen_count: assert property (@(posedge clk) disable iff (!rst_n)
    fire && mode != MODE_CLEAR && !control_r[CTRL_COUNT_EN] |=> $stable(count_r))
    else $error("count moved while counting disabled");

  a_read_only_data: assert property (@(posedge clk) disable iff (!rst_n)
    result.read_data != '0 |-> mode == MODE_READ)
    else $error("read data outside a read");

  a_irq_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
    (result.compare_irq || result.overflow_irq) |-> mode == MODE_TICK)
    else $error("interrupt pulse outside a tick");

endmodule

// ----- rtl/timer_compare_overflow_regs.sv -----
// ----------------------------------------------------------------------------
// timer_compare_overflow_regs: 8-bit timer with compare and overflow pulses
// Input register, register-file logic, then a result register.
// ----------------------------------------------------------------------------
// An accepted item waits in the input register, then its result is captured in the result register.
// Throughput: one item per cycle; the result register stalls only on out_ready.
// Registers update as an item leaves the input register, in arrival order.
// Reset (rst_n low, synchronous) empties both stages and zeroes count, control and compare.
module timer_compare_overflow_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tco_pkg::MODE_W-1:0]  in_mode,
  input  logic [tco_pkg::ADDR_W-1:0]  in_address,
  input  logic [tco_pkg::DATA_W-1:0]  in_write_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tco_pkg::DATA_W-1:0]  out_read_data,
  output logic                        out_compare_irq,
  output logic                        out_overflow_irq
);
  import tco_pkg::*;

  logic              in_valid_r;
  logic [MODE_W-1:0] mode_r;
  logic [ADDR_W-1:0] address_r;
  logic [DATA_W-1:0] write_data_r;
  logic              out_valid_r;
  tco_result_t       result;
  tco_result_t       result_r;
  logic              out_free;
  logic              advance;

  // Handshake: stage 2 frees when empty or drained; stage 1 when empty or when it advances
  assign out_free = !out_valid_r || out_ready;
  assign advance  = in_valid_r && out_free;
  assign in_ready = !in_valid_r || advance;

  // Capture the incoming transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r       <= in_mode;
      address_r    <= in_address;
      write_data_r <= in_write_data;
    end
  end

  tco_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (advance),
    .mode       (mode_r),
    .address    (address_r),
    .write_data (write_data_r),
    .result     (result)
  );

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = result_r.read_data;
  assign out_compare_irq  = result_r.compare_irq;
  assign out_overflow_irq = result_r.overflow_irq;

  a_hold_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !out_free |=> in_valid_r && $stable(mode_r))
    else $error("input stage lost a stalled transaction");

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced transaction missing from result stage");

  a_no_ready_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("accepted while both stages stalled");

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for timer_compare_overflow_regs
// Drives tick, read, write and clear transactions through the valid/ready
// input channel. A behavioral timer model predicts every result, and a
// monitor checks each result transaction in order. Random stalls fall on both
// channels, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tco_pkg::*;

  localparam int unsigned RANDOM_OPS   = 1750;
  localparam int unsigned PHASE1_START = 600;
  localparam int unsigned PHASE2_START = 1200;
  localparam int unsigned HOLD_AT      = 200;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] wdata;
  } bus_op_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [MODE_W-1:0] in_mode = MODE_TICK;
  logic [ADDR_W-1:0] in_address = '0;
  logic [DATA_W-1:0] in_write_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DATA_W-1:0] out_read_data;
  logic              out_compare_irq;
  logic              out_overflow_irq;

  // timer model state
  logic [DATA_W-1:0] tmr_count = '0;
  logic [DATA_W-1:0] tmr_control = '0;
  logic [DATA_W-1:0] tmr_compare = '0;

  bus_op_t     bus_ops_q[$];
  tco_result_t timer_results_q[$];

  int unsigned ops_accepted = 0;
  int unsigned err_cnt = 0;
  int unsigned stall_cycles = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;

  timer_compare_overflow_regs DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_address       (in_address),
    .in_write_data    (in_write_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_data    (out_read_data),
    .out_compare_irq  (out_compare_irq),
    .out_overflow_irq (out_overflow_irq)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one transaction to the timer model and return the result it causes
  function automatic tco_result_t timer_apply(input logic [MODE_W-1:0] mode,
                                              input logic [ADDR_W-1:0] addr,
                                              input logic [DATA_W-1:0] wdata);
    tco_result_t res;
    res = '0;
    case (mode)
      MODE_TICK: begin
        if (tmr_control[CTRL_COUNT_EN]) begin
          tmr_count = tmr_count + 8'd1;
          res.compare_irq  = tmr_control[CTRL_CMP_IE] && (tmr_count == tmr_compare);
          res.overflow_irq = tmr_control[CTRL_OVF_IE] && (tmr_count == 8'd0);
        end
      end
      MODE_READ: begin
        case (addr)
          ADDR_CONTROL: res.read_data = tmr_control;
          ADDR_COUNT:   res.read_data = tmr_count;
          ADDR_COMPARE: res.read_data = tmr_compare;
          default:      res.read_data = '0;
        endcase
      end
      MODE_WRITE: begin
        if (addr == ADDR_CONTROL) begin
          tmr_control = wdata;
        end else if (addr == ADDR_COMPARE) begin
          tmr_compare = wdata;
        end
      end
      default: begin
        tmr_count   = '0;
        tmr_control = '0;
        tmr_compare = '0;
      end
    endcase
    return res;
  endfunction

  task automatic push_op(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] addr,
                         input logic [DATA_W-1:0] wdata);
    bus_op_t op;
    op.mode    = mode;
    op.address = addr;
    op.wdata   = wdata;
    bus_ops_q.push_back(op);
  endtask

  function automatic logic [ADDR_W-1:0] pick_reg_addr();
    case ($urandom_range(0, 2))
      0:       return ADDR_CONTROL;
      1:       return ADDR_COUNT;
      default: return ADDR_COMPARE;
    endcase
  endfunction

  // Idle rates per phase, stepped by accepted input transactions
  always_comb begin
    if (ops_accepted < PHASE1_START) begin
      tx_idle_pct = 8;
      rx_idle_pct = 57;
    end else if (ops_accepted < PHASE2_START) begin
      tx_idle_pct = 57;
      rx_idle_pct = 8;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  end

  // Fill the pending queue: directed cases, then random timer sequences
  initial begin
    int unsigned sel;
    int unsigned n;
    int unsigned r;
    logic [DATA_W-1:0] ctl;

    // reset values and unmapped read
    push_op(MODE_READ, ADDR_CONTROL, 8'h00);
    push_op(MODE_READ, ADDR_COUNT, 8'h00);
    push_op(MODE_READ, ADDR_COMPARE, 8'h00);
    push_op(MODE_READ, 8'hFF, 8'hFF);
    // tick while disabled
    push_op(MODE_TICK, 8'h00, 8'h00);
    // writes: compare extreme, ignored count and unmapped writes
    push_op(MODE_WRITE, ADDR_COMPARE, 8'hFF);
    push_op(MODE_WRITE, ADDR_COUNT, 8'h55);
    push_op(MODE_WRITE, 8'h0C, 8'hAA);
    push_op(MODE_WRITE, ADDR_CONTROL, 8'hFF);
    push_op(MODE_READ, ADDR_CONTROL, 8'h00);
    push_op(MODE_TICK, 8'h00, 8'h00);
    // compare hit
    push_op(MODE_WRITE, ADDR_COMPARE, 8'h02);
    push_op(MODE_TICK, 8'hFF, 8'hFF);
    push_op(MODE_READ, ADDR_COUNT, 8'h00);
    // freeze with interrupts still enabled, then resume
    push_op(MODE_WRITE, ADDR_CONTROL, 8'h06);
    push_op(MODE_TICK, 8'h00, 8'h00);
    push_op(MODE_READ, ADDR_COUNT, 8'h00);
    push_op(MODE_WRITE, ADDR_CONTROL, 8'h01);
    push_op(MODE_TICK, 8'h00, 8'h00);
    push_op(MODE_WRITE, ADDR_COMPARE, 8'h00);
    // clear everything and read back
    push_op(MODE_CLEAR, 8'hFF, 8'hFF);
    push_op(MODE_READ, ADDR_CONTROL, 8'h00);
    push_op(MODE_READ, ADDR_COUNT, 8'h00);
    push_op(MODE_READ, ADDR_COMPARE, 8'h00);
    push_op(MODE_READ, 8'h80, 8'h00);

    // random part: mostly enable-and-tick bursts, some noise and clears
    n = bus_ops_q.size() + RANDOM_OPS;
    while (bus_ops_q.size() < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 80) begin
        ctl = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 85) ctl[CTRL_COUNT_EN] = 1'b1;
        push_op(MODE_WRITE, ADDR_CONTROL, ctl);
        if ($urandom_range(0, 1) == 1) begin
          push_op(MODE_WRITE, ADDR_COMPARE, 8'($urandom_range(0, 255)));
        end
        repeat ($urandom_range(20, 300)) begin
          r = $urandom_range(0, 99);
          if (r < 80) begin
            push_op(MODE_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          end else if (r < 92) begin
            push_op(MODE_READ, pick_reg_addr(), 8'($urandom_range(0, 255)));
          end else if (r < 97) begin
            push_op(MODE_WRITE, ADDR_COMPARE, 8'($urandom_range(0, 255)));
          end else begin
            push_op(MODE_WRITE, ADDR_CONTROL, 8'($urandom_range(0, 255)));
          end
        end
      end else if (sel < 96) begin
        repeat (12) begin
          push_op(2'($urandom_range(0, 2)),
                  ($urandom_range(0, 1) == 1) ? pick_reg_addr() : 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
        end
      end else begin
        push_op(MODE_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
    end
  end

  // Driver: predict on acceptance, hold the payload while stalled
  always @(posedge clk) begin
    bus_op_t op;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        timer_results_q.push_back(timer_apply(in_mode, in_address, in_write_data));
        ops_accepted <= ops_accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (bus_ops_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          op = bus_ops_q.pop_front();
          in_valid      <= 1'b1;
          in_mode       <= op.mode;
          in_address    <= op.address;
          in_write_data <= op.wdata;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off to back up the pipeline
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && ops_accepted >= HOLD_AT) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    tco_result_t exp_res;
    int unsigned errs;
    errs = 0;
    if (rst_n && out_valid && out_ready) begin
      if (timer_results_q.size() == 0) begin
        $display("%0t: unexpected result read_data %02h compare_irq %0b overflow_irq %0b",
                 $time, out_read_data, out_compare_irq, out_overflow_irq);
        errs = errs + 1;
      end else begin
        exp_res = timer_results_q.pop_front();
        if (out_read_data !== exp_res.read_data) begin
          $display("%0t: read_data expected %02h actual %02h",
                   $time, exp_res.read_data, out_read_data);
          errs = errs + 1;
        end
        if (out_compare_irq !== exp_res.compare_irq) begin
          $display("%0t: compare_irq expected %0b actual %0b",
                   $time, exp_res.compare_irq, out_compare_irq);
          errs = errs + 1;
        end
        if (out_overflow_irq !== exp_res.overflow_irq) begin
          $display("%0t: overflow_irq expected %0b actual %0b",
                   $time, exp_res.overflow_irq, out_overflow_irq);
          errs = errs + 1;
        end
      end
    end
    if (errs != 0) begin
      err_cnt <= err_cnt + errs;
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
        $display("end of test: mismatches");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Reset, wait for the drain, then report
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (bus_ops_q.size() > 0 || in_valid || timer_results_q.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && timer_results_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
